/* hw/rtl/lfu_page_replacement_core_macros.svh */
// Assertion macros shared by the LFU replacement checker.
`ifndef LFU_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define LFU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define LFU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU replacement package
// Sizes, cell commands, wave record and controller states shared by the core.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int CAPACITY   = 16;
    localparam int COUNT_BITS = 16;
    localparam int PAGE_W     = 31;
    localparam int LIMIT_W    = 5;
    localparam int FAULT_W    = 32;
    localparam int RES_W      = 5;
    localparam int CNT_W      = COUNT_BITS;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INC,
        CELL_LOAD,
        CELL_SHIFT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      active;
        logic      first;
    } t_cell_ctl;

    // Running minimum handed from the oldest cell toward the newest.
    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [IDX_W-1:0]  idx;
        logic [PAGE_W-1:0] tag;
    } t_wave;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_EVICT
    } t_state;

endpackage

/* hw/rtl/lfu_cell.sv */
// ----------------------------------------------------------------------------
// LFU slot cell
// Holds one resident page and its use count, compares it with the request,
// and passes the running minimum count to the next newer slot every cycle.
// ----------------------------------------------------------------------------
module lfu_cell (
    input  logic                      i_clk,
    input  lfu_pkg::t_cell_ctl        i_ctl,
    input  logic [lfu_pkg::IDX_W-1:0] i_index,
    input  logic [lfu_pkg::PAGE_W-1:0] i_page,
    input  logic [lfu_pkg::PAGE_W-1:0] i_next_tag,
    input  logic [lfu_pkg::CNT_W-1:0] i_next_cnt,
    input  lfu_pkg::t_wave            i_wave,
    output logic [lfu_pkg::PAGE_W-1:0] o_tag,
    output logic [lfu_pkg::CNT_W-1:0] o_cnt,
    output logic                      o_match,
    output lfu_pkg::t_wave            o_wave
);
    import lfu_pkg::*;

    logic [PAGE_W-1:0] r_tag, n_tag;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_wave             r_wave, n_wave;

    always_comb begin
        n_tag = r_tag;
        n_cnt = r_cnt;
        case (i_ctl.cmd)
            CELL_HOLD: begin
                n_tag = r_tag;
            end
            CELL_INC: begin
                if (r_cnt != {CNT_W{1'b1}}) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            CELL_LOAD: begin
                n_tag = i_page;
                n_cnt = CNT_W'(1);
            end
            CELL_SHIFT: begin
                n_tag = i_next_tag;
                n_cnt = i_next_cnt;
            end
            default: begin
                n_tag = r_tag;
            end
        endcase
    end

    // Strict less-than keeps the older slot on equal counts.
    always_comb begin
        n_wave = i_wave;
        if (i_ctl.active && (i_ctl.first || (r_cnt < i_wave.cnt))) begin
            n_wave.cnt = r_cnt;
            n_wave.idx = i_index;
            n_wave.tag = r_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_cnt  <= n_cnt;
        r_wave <= n_wave;
    end

    assign o_tag   = r_tag;
    assign o_cnt   = r_cnt;
    assign o_match = i_ctl.active && (r_tag == i_page);
    assign o_wave  = r_wave;

endmodule

/* hw/rtl/lfu_page_replacement_core.sv */
// ----------------------------------------------------------------------------
// LFU page replacement core
// Looks up page requests in a row of slot cells and keeps least frequently
// used replacement with oldest-first tie breaking.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers at a rising edge with start high and busy low; i_page
//   carries the page number. Exactly one result follows, shown on the o_ ports
//   for one cycle while o_valid is high. The receiver cannot stall, so results
//   must be taken as they appear.
//   Hits and misses that find a free frame keep busy high only in S_LOOK; the
//   result strobes as busy falls, and no new request is taken before then. A
//   miss that must evict keeps busy high through S_LOOK, S_SCAN and S_EVICT:
//   the minimum count travels through the cell row one slot per cycle, and
//   the controller waits for it to leave the newest slot. The user must write
//   the frame limit through i_cfg_we and i_cfg_wdata only while idle; the core
//   itself does not enforce this. Reset empties the cache, clears the fault
//   total and sets the frame limit to 16. Page tags and counts are not
//   cleared; only slots below the occupancy are ever looked at.
module lfu_page_replacement_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [lfu_pkg::PAGE_W-1:0]   i_page,
    input  logic                         i_cfg_we,
    input  logic [lfu_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic                         o_evicted_valid,
    output logic [lfu_pkg::PAGE_W-1:0]   o_evicted_page,
    output logic [lfu_pkg::FAULT_W-1:0]  o_fault_total,
    output logic [lfu_pkg::RES_W-1:0]    o_resident_count
);
    import lfu_pkg::*;

    t_state              r_state, n_state;
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic [FAULT_W-1:0]  r_faults, n_faults;
    logic [LIMIT_W-1:0]  r_limit;
    logic [IDX_W-1:0]    r_scan, n_scan;
    logic                r_valid, n_valid;
    logic [PAGE_W-1:0]   r_page;
    logic                r_hit, n_hit;
    logic                r_ev_valid, n_ev_valid;
    logic [PAGE_W-1:0]   r_ev_page, n_ev_page;

    t_cell_ctl           ctl      [CAPACITY];
    logic [PAGE_W-1:0]   tags     [CAPACITY];
    logic [CNT_W-1:0]    cnts     [CAPACITY];
    logic [PAGE_W-1:0]   next_tag [CAPACITY];
    logic [CNT_W-1:0]    next_cnt [CAPACITY];
    t_wave               wave_in  [CAPACITY];
    t_wave               wave_out [CAPACITY];
    logic [CAPACITY-1:0] match;

    logic [CMP_W-1:0]    eff_limit;
    logic                need_evict;
    logic [FAULT_W-1:0]  faults_inc;
    logic                accept;
    t_wave               victim;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign wave_in[g] = '0;
            end else begin : g_link
                assign wave_in[g] = wave_out[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign next_tag[g] = '0;
                assign next_cnt[g] = '0;
            end else begin : g_body
                assign next_tag[g] = tags[g+1];
                assign next_cnt[g] = cnts[g+1];
            end
            lfu_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl[g]),
                .i_index    (IDX_W'(g)),
                .i_page     (r_page),
                .i_next_tag (next_tag[g]),
                .i_next_cnt (next_cnt[g]),
                .i_wave     (wave_in[g]),
                .o_tag      (tags[g]),
                .o_cnt      (cnts[g]),
                .o_match    (match[g]),
                .o_wave     (wave_out[g])
            );
        end
    endgenerate

    assign victim = wave_out[CAPACITY-1];
    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        eff_limit = CMP_W'(r_limit);
        if (r_limit == '0) begin
            eff_limit = CMP_W'(1);
        end else if (CMP_W'(r_limit) > CMP_W'(CAPACITY)) begin
            eff_limit = CMP_W'(CAPACITY);
        end
        need_evict = (CMP_W'(r_occ) >= eff_limit);
        faults_inc = (r_faults == {FAULT_W{1'b1}}) ? r_faults : (r_faults + FAULT_W'(1));
    end

    always_comb begin
        n_state    = r_state;
        n_occ      = r_occ;
        n_faults   = r_faults;
        n_scan     = r_scan;
        n_valid    = 1'b0;
        n_hit      = r_hit;
        n_ev_valid = r_ev_valid;
        n_ev_page  = r_ev_page;
        for (int i = 0; i < CAPACITY; i++) begin
            ctl[i].cmd    = CELL_HOLD;
            ctl[i].active = (OCC_W'(i) < r_occ);
            ctl[i].first  = (i == 0);
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (|match) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (match[i]) begin
                            ctl[i].cmd = CELL_INC;
                        end
                    end
                    n_hit      = 1'b1;
                    n_ev_valid = 1'b0;
                    n_ev_page  = '0;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end else if (!need_evict) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (OCC_W'(i) == r_occ) begin
                            ctl[i].cmd = CELL_LOAD;
                        end
                    end
                    n_occ      = r_occ + OCC_W'(1);
                    n_faults   = faults_inc;
                    n_hit      = 1'b0;
                    n_ev_valid = 1'b0;
                    n_ev_page  = '0;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_scan  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_scan == IDX_W'(CAPACITY - 1)) begin
                    n_state = S_EVICT;
                end else begin
                    n_scan = r_scan + IDX_W'(1);
                end
            end
            S_EVICT: begin
                // Slots above the victim move one place older; the new page
                // takes the newest slot, so occupancy stays the same.
                for (int i = 0; i < CAPACITY; i++) begin
                    if (OCC_W'(i) == r_occ - OCC_W'(1)) begin
                        ctl[i].cmd = CELL_LOAD;
                    end else if ((IDX_W'(i) >= victim.idx) && (OCC_W'(i) < r_occ)) begin
                        ctl[i].cmd = CELL_SHIFT;
                    end
                end
                n_faults   = faults_inc;
                n_hit      = 1'b0;
                n_ev_valid = 1'b1;
                n_ev_page  = victim.tag;
                n_valid    = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_faults <= '0;
            r_limit  <= LIMIT_RESET;
            r_scan   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_occ    <= n_occ;
            r_faults <= n_faults;
            r_scan   <= n_scan;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page <= i_page;
        end
        r_hit      <= n_hit;
        r_ev_valid <= n_ev_valid;
        r_ev_page  <= n_ev_page;
    end

    assign o_valid          = r_valid;
    assign o_hit            = r_hit;
    assign o_evicted_valid  = r_ev_valid;
    assign o_evicted_page   = r_ev_page;
    assign o_fault_total    = r_faults;
    assign o_resident_count = RES_W'(r_occ);

endmodule

/* hw/rtl/lfu_checker.sv */
// ----------------------------------------------------------------------------
// LFU replacement port checker
// Watches the core's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "lfu_page_replacement_core_macros.svh"

module lfu_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_valid,
    input logic                         o_hit,
    input logic                         o_evicted_valid,
    input logic [lfu_pkg::RES_W-1:0]    o_resident_count
);
    import lfu_pkg::*;

    // A transfer always keeps the core busy for at least the lookup cycle.
    `LFU_ASSERT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "busy not raised")

    // Results never strobe back to back.
    `LFU_ASSERT(a_valid_gap, i_clk, i_rst_n, o_valid |=> !o_valid, "back-to-back results")

    // A hit never evicts, and a miss always leaves at least one page resident.
    `LFU_ASSERT(a_hit_no_evict, i_clk, i_rst_n, (o_valid && o_hit) |-> !o_evicted_valid, "hit evicted a page")
    `LFU_ASSERT(a_miss_resident, i_clk, i_rst_n, (o_valid && !o_hit) |-> (o_resident_count != '0), "miss left cache empty")

    // Reset leaves the core idle with no result pending.
    `LFU_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> (!o_valid && !busy), "not idle after reset")

endmodule

bind lfu_page_replacement_core lfu_checker u_lfu_checker (.*);

/* verif/tb_lfu_page_replacement_core.sv */
// ----------------------------------------------------------------------------
// Testbench for the LFU page replacement core
// Sends page requests through the start/busy handshake and predicts every
// result with its own model of the resident set, use counts and fault total.
// Directed requests cover the limit edge cases and tie breaking. Random phases
// under several frame limits follow, and a hot page is checked to outlast a
// run of misses. Each strobed result is checked field by field.
// ----------------------------------------------------------------------------
module tb_lfu_page_replacement_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lfu_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = CAPACITY + 4;
    localparam int PHASE_ITEMS   = 80;

    typedef logic [PAGE_W-1:0] t_page;

    localparam t_page               PAGE_TOP   = '1;
    localparam logic [CNT_W-1:0]    COUNT_CEIL = '1;
    localparam logic [FAULT_W-1:0]  FAULT_CEIL = '1;

    typedef struct packed {
        logic                hit;
        logic                evicted_valid;
        t_page               evicted_page;
        logic [FAULT_W-1:0]  fault_total;
        logic [RES_W-1:0]    resident_count;
    } t_outcome;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    t_page               i_page      = '0;
    logic                i_cfg_we    = 1'b0;
    logic [LIMIT_W-1:0]  i_cfg_wdata = '0;
    logic                o_valid;
    logic                o_hit;
    logic                o_evicted_valid;
    t_page               o_evicted_page;
    logic [FAULT_W-1:0]  o_fault_total;
    logic [RES_W-1:0]    o_resident_count;

    // Resident set as the block should hold it, oldest page in slot 0.
    t_page               model_tags   [CAPACITY];
    logic [CNT_W-1:0]    model_counts [CAPACITY];
    int                  model_occ    = 0;
    logic [FAULT_W-1:0]  model_faults = '0;
    logic [LIMIT_W-1:0]  model_limit  = LIMIT_RESET;

    t_outcome            outcomes_due [$];
    t_outcome            due;
    int                  errors          = 0;
    int                  requests_sent   = 0;
    int                  hits_seen       = 0;
    int                  evictions_seen  = 0;
    int                  results_checked = 0;
    int                  cycle_count     = 0;

    lfu_page_replacement_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_page           (i_page),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_hit            (o_hit),
        .o_evicted_valid  (o_evicted_valid),
        .o_evicted_page   (o_evicted_page),
        .o_fault_total    (o_fault_total),
        .o_resident_count (o_resident_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_lfu_page_replacement_core: done, errors");
            $finish;
        end
    end

    function automatic t_outcome access_page(t_page pg);
        t_outcome r;
        int       eff;
        int       slot;
        int       victim;
        r    = '0;
        eff  = (model_limit == 0) ? 1 :
               ((model_limit > CAPACITY) ? CAPACITY : int'(model_limit));
        slot = -1;
        for (int i = 0; i < model_occ; i++) begin
            if (slot < 0 && model_tags[i] == pg) slot = i;
        end
        if (slot >= 0) begin
            r.hit = 1'b1;
            if (model_counts[slot] != COUNT_CEIL) model_counts[slot]++;
        end else begin
            if (model_faults != FAULT_CEIL) model_faults++;
            if (model_occ >= eff) begin
                // Lowest count goes; a strict compare keeps the oldest on ties.
                victim = 0;
                for (int i = 1; i < model_occ; i++) begin
                    if (model_counts[i] < model_counts[victim]) victim = i;
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = model_tags[victim];
                for (int i = victim; i < model_occ - 1; i++) begin
                    model_tags[i]   = model_tags[i + 1];
                    model_counts[i] = model_counts[i + 1];
                end
                model_occ--;
            end
            if (model_occ < CAPACITY) begin
                model_tags[model_occ]   = pg;
                model_counts[model_occ] = CNT_W'(1);
                model_occ++;
            end
        end
        r.fault_total    = model_faults;
        r.resident_count = RES_W'(model_occ);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t: mismatch on %s after %0d results: got %0h, want %0h",
                 $time, what, results_checked, got, want);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (outcomes_due.size() == 0) begin
                report_mismatch("result with no request outstanding",
                                64'(o_evicted_page), '0);
            end else begin
                due = outcomes_due.pop_front();
                results_checked++;
                if (o_hit !== due.hit)
                    report_mismatch("hit", 64'(o_hit), 64'(due.hit));
                if (o_evicted_valid !== due.evicted_valid)
                    report_mismatch("evicted_valid", 64'(o_evicted_valid),
                                    64'(due.evicted_valid));
                if (o_evicted_page !== due.evicted_page)
                    report_mismatch("evicted_page", 64'(o_evicted_page),
                                    64'(due.evicted_page));
                if (o_fault_total !== due.fault_total)
                    report_mismatch("fault_total", 64'(o_fault_total),
                                    64'(due.fault_total));
                if (o_resident_count !== due.resident_count)
                    report_mismatch("resident_count", 64'(o_resident_count),
                                    64'(due.resident_count));
            end
        end
    end

    // Start stays high after a transfer so that a back-to-back request does
    // not drop it; anything that stops sending goes through wait_drained.
    task automatic send_page(input t_page pg, input int gap);
        t_outcome r;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_page <= pg;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = access_page(pg);
        outcomes_due.push_back(r);
        requests_sent++;
        if (r.hit) hits_seen++;
        if (r.evicted_valid) evictions_seen++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (outcomes_due.size() != 0 || busy !== 1'b0);
    endtask

    task automatic set_frame_limit(input logic [LIMIT_W-1:0] lim);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lim;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_limit = lim;
    endtask

    task automatic test_limit_zero();
        // A limit of zero behaves as a single frame.
        set_frame_limit('0);
        send_page('0, 0);
        send_page(PAGE_TOP, $urandom_range(0, 7));
        send_page(PAGE_TOP, $urandom_range(0, 7));
    endtask

    task automatic test_tie_oldest();
        set_frame_limit(LIMIT_W'(3));
        send_page(31'h2AAA_AAAA, 0);
        send_page(31'h5555_5555, $urandom_range(0, 7));
        send_page(31'h2AAA_AAAA, $urandom_range(0, 7));
        send_page(PAGE_TOP, 0);
        send_page(31'h0000_0001, $urandom_range(0, 7));
        send_page(31'h4000_0000, 0);
    endtask

    task automatic test_limit_lowered();
        set_frame_limit(LIMIT_W'(6));
        send_page(31'h0000_1234, 0);
        send_page(31'h1357_9BDF, $urandom_range(0, 7));
        send_page(31'h7000_0000, 0);
        // Occupancy is now above the new limit; misses swap one page each.
        set_frame_limit(LIMIT_W'(2));
        send_page(31'h0F0F_0F0F, 0);
        send_page(31'h0F0F_0F0F, $urandom_range(0, 7));
        send_page('0, 0);
    endtask

    task automatic test_random_phases();
        logic [LIMIT_W-1:0] limits [8];
        t_page              pool [$];
        t_page              pg;
        int                 eff;
        int                 gap;
        bit                 burst;
        limits = '{LIMIT_W'(1), LIMIT_W'(2), LIMIT_W'(9), LIMIT_W'(12),
                   LIMIT_W'(31), LIMIT_W'(16), LIMIT_W'(0), LIMIT_W'(17)};
        limits[6] = LIMIT_W'($urandom_range(0, 31));
        foreach (limits[p]) begin
            set_frame_limit(limits[p]);
            eff = (limits[p] == 0) ? 1 :
                  ((limits[p] > CAPACITY) ? CAPACITY : int'(limits[p]));
            pool.delete();
            repeat (eff + $urandom_range(1, 6)) pool.push_back(t_page'($urandom));
            if ($urandom_range(0, 2) == 0) pool.push_back('0);
            if ($urandom_range(0, 2) == 0) pool.push_back(PAGE_TOP);
            burst = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 16 == 0) burst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 49) == 0) wait_drained();
                gap = burst ? 0 : $urandom_range(0, 7);
                // Picks lean toward the front of the pool so some pages get hot.
                if ($urandom_range(0, 9) == 0)
                    pg = t_page'($urandom);
                else
                    pg = pool[$urandom_range(0, $urandom_range(0, pool.size() - 1))];
                send_page(pg, gap);
            end
        end
    endtask

    task automatic test_hot_page();
        t_page hot;
        hot = t_page'($urandom);
        set_frame_limit(LIMIT_W'(CAPACITY));
        send_page(hot, 0);
        // Repeated hits make this page the most used, so it survives the
        // misses that follow and still hits afterward.
        repeat (20) send_page(hot, $urandom_range(0, 7));
        repeat (CAPACITY + 4) send_page(t_page'($urandom), $urandom_range(0, 7));
        repeat (3) send_page(hot, 0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_limit_zero();
        test_tie_oldest();
        test_limit_lowered();
        test_random_phases();
        test_hot_page();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d requests (%0d hits, %0d evictions), %0d results checked,",
                 requests_sent, hits_seen, evictions_seen, results_checked);
        $display("under frame limits 0 to 31, a lowered limit and a heavily used page.");
        if (errors == 0) begin
            $display("tb_lfu_page_replacement_core: done, clean");
        end else begin
            $display("tb_lfu_page_replacement_core: done, errors");
        end
        $finish;
    end

endmodule
